>>> sv/lpd_pkg.sv
// types and constants shared by the length-prefixed deframer modules
package lpd_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       chunk_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       msg_last;
		logic       was_rewritten;
	} out_item_t;

	typedef struct packed {
		logic [15:0] max_len;
		logic [15:0] relay_port;
		logic        rewrite_enable;
	} cfg_t;

	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEN        = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RELAY_PORT     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_REWRITE_ENABLE = 2'd2;

	localparam logic [15:0] MAX_LEN_RST        = 16'hffff;
	localparam logic [15:0] RELAY_PORT_RST     = 16'h0000;
	localparam logic        REWRITE_ENABLE_RST = 1'b1;

	localparam logic [7:0]  ACCEPT_CODE    = 8'h81;
	localparam logic [15:0] MIN_ACCEPT_LEN = 16'd9;

endpackage

>>> sv/lpd_cfg.sv
// configuration register file of the deframer
module lpd_cfg
	import lpd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_len        <= MAX_LEN_RST;
			cfg_q.relay_port     <= RELAY_PORT_RST;
			cfg_q.rewrite_enable <= REWRITE_ENABLE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MAX_LEN: begin
					cfg_q.max_len <= cfg_data;
				end
				REG_RELAY_PORT: begin
					cfg_q.relay_port <= cfg_data;
				end
				REG_REWRITE_ENABLE: begin
					cfg_q.rewrite_enable <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/lpd_core.sv
// framing state machine and port rewrite logic, one item per cycle while fire is high
module lpd_core
	import lpd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output logic      res_valid,
	output out_item_t res
);

	localparam logic [1:0] PH_LEN_HI  = 2'd0;
	localparam logic [1:0] PH_LEN_LO  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_DISCARD = 2'd3;

	localparam logic [15:0] IDX_CTL     = 16'd0;
	localparam logic [15:0] IDX_HLEN_HI = 16'd2;
	localparam logic [15:0] IDX_HLEN_LO = 16'd3;
	localparam logic [15:0] IDX_CODE    = 16'd4;
	localparam logic [15:0] IDX_PORT_LO = 16'd5;
	localparam logic [15:0] IDX_PORT_HI = 16'd6;
	localparam logic [15:0] IDX_ZERO_A  = 16'd7;
	localparam logic [15:0] IDX_ZERO_B  = 16'd8;

	logic [1:0]  phase_q, phase_d;
	logic [15:0] msg_length_q, msg_length_d;
	logic [15:0] byte_index_q, byte_index_d;
	logic        ctl_flag_seen_q, ctl_flag_seen_d;
	logic [15:0] header_length_q, header_length_d;
	logic        rewrite_active_q, rewrite_active_d;
	logic [15:0] len_full;
	logic        last;

	always_comb begin
		phase_d          = phase_q;
		msg_length_d     = msg_length_q;
		byte_index_d     = byte_index_q;
		ctl_flag_seen_d  = ctl_flag_seen_q;
		header_length_d  = header_length_q;
		rewrite_active_d = rewrite_active_q;
		res_valid        = 1'b0;
		res.out_byte      = item.in_byte;
		res.msg_last      = 1'b0;
		res.was_rewritten = 1'b0;
		len_full = {msg_length_q[15:8], item.in_byte};
		last = ({1'b0, byte_index_q} + 17'd1) >= {1'b0, msg_length_q};

		unique case (phase_q)
			PH_LEN_HI: begin
				msg_length_d = {item.in_byte, 8'h00};
				phase_d      = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				msg_length_d = len_full;
				if (len_full == 16'd0 || len_full > cfg.max_len) begin
					if (item.chunk_end) begin
						phase_d          = PH_LEN_HI;
						byte_index_d     = 16'd0;
						ctl_flag_seen_d  = 1'b0;
						header_length_d  = 16'd0;
						rewrite_active_d = 1'b0;
					end else begin
						phase_d = PH_DISCARD;
					end
				end else begin
					phase_d          = PH_PAYLOAD;
					byte_index_d     = 16'd0;
					ctl_flag_seen_d  = 1'b0;
					header_length_d  = 16'd0;
					rewrite_active_d = 1'b0;
				end
			end
			PH_DISCARD: begin
				if (item.chunk_end) begin
					phase_d          = PH_LEN_HI;
					byte_index_d     = 16'd0;
					ctl_flag_seen_d  = 1'b0;
					header_length_d  = 16'd0;
					rewrite_active_d = 1'b0;
				end
			end
			PH_PAYLOAD: begin
				res_valid    = 1'b1;
				res.msg_last = last;
				unique case (byte_index_q)
					IDX_CTL: begin
						ctl_flag_seen_d = item.in_byte[7];
					end
					IDX_HLEN_HI: begin
						header_length_d = {item.in_byte, 8'h00};
					end
					IDX_HLEN_LO: begin
						header_length_d = {header_length_q[15:8], item.in_byte};
					end
					IDX_CODE: begin
						rewrite_active_d = cfg.rewrite_enable
							&& (msg_length_q >= MIN_ACCEPT_LEN)
							&& ctl_flag_seen_q
							&& (header_length_q >= MIN_ACCEPT_LEN)
							&& (item.in_byte == ACCEPT_CODE);
					end
					IDX_PORT_LO: begin
						if (rewrite_active_q) begin
							res.was_rewritten = 1'b1;
							res.out_byte      = cfg.relay_port[7:0];
						end
					end
					IDX_PORT_HI: begin
						if (rewrite_active_q) begin
							res.was_rewritten = 1'b1;
							res.out_byte      = cfg.relay_port[15:8];
						end
					end
					IDX_ZERO_A, IDX_ZERO_B: begin
						if (rewrite_active_q) begin
							res.was_rewritten = 1'b1;
							res.out_byte      = 8'h00;
						end
					end
					default: begin
					end
				endcase
				if (last) begin
					phase_d          = PH_LEN_HI;
					byte_index_d     = 16'd0;
					ctl_flag_seen_d  = 1'b0;
					header_length_d  = 16'd0;
					rewrite_active_d = 1'b0;
				end else begin
					byte_index_d = byte_index_q + 16'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_LEN_HI;
			msg_length_q     <= 16'd0;
			byte_index_q     <= 16'd0;
			ctl_flag_seen_q  <= 1'b0;
			header_length_q  <= 16'd0;
			rewrite_active_q <= 1'b0;
		end else if (fire) begin
			phase_q          <= phase_d;
			msg_length_q     <= msg_length_d;
			byte_index_q     <= byte_index_d;
			ctl_flag_seen_q  <= ctl_flag_seen_d;
			header_length_q  <= header_length_d;
			rewrite_active_q <= rewrite_active_d;
		end
	end

endmodule

>>> sv/length_prefixed_deframer_port_rewrite.sv
// Length-prefixed byte deframer with accept-reply port rewrite. Bytes enter on
// in_valid/in_stall, payload bytes leave on out_valid/out_stall; length bytes and
// discarded bytes produce no output item. One byte is taken every cycle: an input
// register feeds the framing state machine, whose result lands in an output
// register, so a result item passes through the input register and then the
// output register before it is presented, and the input stalls only while the
// output register is full and held. Configuration writes must be made while no
// byte is in flight.
module length_prefixed_deframer_port_rewrite
	import lpd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_item,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_item,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res;
	logic      res_valid;
	out_item_t out_q;
	logic      out_valid_q;
	logic      adv;
	logic      fire;
	logic      in_acc;

	assign adv      = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	lpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lpd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

>>> sv/lpd_checker.sv
// port-level assertions for the deframer, bound to the top level
module lpd_checker
	import lpd_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output register can move");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_item)))
		else $error("stalled output item changed or dropped");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> (!out_valid && !in_stall))
		else $error("handshake active during reset");

endmodule

bind length_prefixed_deframer_port_rewrite lpd_checker u_lpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
